// ===== design/bfst_pkg.sv =====
// bfst_pkg: shared widths, codes and types for the best-fit compartment table.
// Used by every module of the design; no dependencies of its own.

package bfst_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);

    localparam int CMD_W   = 3;
    localparam int DIM_W   = 8;
    localparam int NUM_W   = 8;
    localparam int ADDR_W  = 7;
    localparam int AREA_W  = 2 * DIM_W;
    localparam int STAT_W  = 2;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = CMD_W;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 1 + STAT_W;

    localparam logic [AREA_W-1:0] BEST_INIT = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_REMOVE    = 3'd1,
        CMD_BEST      = 3'd2,
        CMD_FIND_NUM  = 3'd3,
        CMD_FIND_ADDR = 3'd4,
        CMD_CLEAR     = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_NOMATCH = 2'd2
    } t_status;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [NUM_W-1:0]  number;
        logic [ADDR_W-1:0] address;
    } t_entry;

    // shared control broadcast to every cell of the chain
    typedef struct packed {
        logic             rotate;
        logic             compact;
        logic             write;
        logic [IDX_W-1:0] sel;
    } t_cell_ctrl;

endpackage

// ===== design/bfst_cell.sv =====
// bfst_cell: one compartment entry of the table, shifting with its neighbour.
// Depends on bfst_pkg.

module bfst_cell import bfst_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [IDX_W-1:0] i_index,
    input  t_entry           i_wr_entry,
    input  t_entry           i_next,
    output t_entry           o_entry
);

    t_entry r_entry;
    logic   load;
    logic   take_next;

    assign load      = i_ctrl.write && (i_ctrl.sel == i_index);
    // compaction pulls every entry at or above the removed slot down by one
    assign take_next = i_ctrl.rotate || (i_ctrl.compact && (i_index >= i_ctrl.sel));

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_entry <= i_wr_entry;
        end else if (take_next) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== design/bfst_ctrl.sv =====
// bfst_ctrl: sequencer, head-of-chain search unit and result register.
// Depends on bfst_pkg; drives the bfst_cell chain through t_cell_ctrl.

module bfst_ctrl import bfst_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  logic [CMD_W-1:0] i_req_cmd,
    input  t_entry           i_req_entry,
    input  t_entry           i_head,
    output t_cell_ctrl       o_cell_ctrl,
    output t_entry           o_wr_entry,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic             o_res_found,
    output t_status          o_res_status,
    output t_entry           o_res_entry
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(SLOTS - 1);

    t_state             r_state,     n_state;
    logic [IDX_W-1:0]   r_step,      n_step;
    logic [CNT_W-1:0]   r_count,     n_count;
    t_cmd               r_cmd,       n_cmd;
    t_entry             r_req,       n_req;
    logic [AREA_W-1:0]  r_need,      n_need;
    logic [AREA_W-1:0]  r_best,      n_best;
    logic               r_hit,       n_hit;
    logic [IDX_W-1:0]   r_sel,       n_sel;
    t_entry             r_res,       n_res;
    t_status            r_status,    n_status;
    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    t_status            r_out_status, n_out_status;
    t_entry             r_out_entry, n_out_entry;

    logic [AREA_W-1:0]  req_area;
    logic [AREA_W-1:0]  head_area;
    logic [AREA_W-1:0]  head_left;
    logic               head_valid;
    logic               head_fit;
    logic               table_full;
    logic               lookup_hit;

    assign req_area   = AREA_W'(i_req_entry.width) * AREA_W'(i_req_entry.height);
    assign head_area  = AREA_W'(i_head.width) * AREA_W'(i_head.height);
    assign head_left  = head_area - r_need;
    assign head_valid = CNT_W'(r_step) < r_count;
    assign head_fit   = head_valid && (i_head.width >= r_req.width)
                        && (i_head.height >= r_req.height);
    assign table_full = r_count == CNT_W'(SLOTS);
    assign lookup_hit = r_hit && (r_cmd != CMD_REMOVE);

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_req        = r_req;
        n_need       = r_need;
        n_best       = r_best;
        n_hit        = r_hit;
        n_sel        = r_sel;
        n_res        = r_res;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;

        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_cmd  = t_cmd'(i_req_cmd);
                    n_req  = i_req_entry;
                    n_need = req_area;
                    n_best = BEST_INIT;
                    n_hit  = 1'b0;
                    n_step = '0;
                    n_sel  = '0;
                    n_res  = '0;
                    unique case (t_cmd'(i_req_cmd)) inside
                        CMD_REMOVE, CMD_BEST, CMD_FIND_NUM, CMD_FIND_ADDR: n_state = S_SCAN;
                        default: n_state = S_UPDATE;
                    endcase
                end
            end
            S_SCAN: begin
                // the ring presents entry r_step at the head this cycle
                unique case (r_cmd)
                    CMD_BEST: begin
                        if (head_fit && (head_left < r_best)) begin
                            n_best = head_left;
                            n_hit  = 1'b1;
                            n_res  = i_head;
                        end
                    end
                    CMD_REMOVE, CMD_FIND_NUM: begin
                        if (head_valid && !r_hit && (i_head.number == r_req.number)) begin
                            n_hit = 1'b1;
                            n_res = i_head;
                            n_sel = r_step;
                        end
                    end
                    CMD_FIND_ADDR: begin
                        if (head_valid && !r_hit && (i_head.address == r_req.address)) begin
                            n_hit = 1'b1;
                            n_res = i_head;
                        end
                    end
                    default: ;
                endcase
                if (r_step == LAST_STEP) begin
                    n_state = S_UPDATE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_UPDATE: begin
                n_state  = S_DONE;
                n_status = STAT_OK;
                unique case (r_cmd)
                    CMD_APPEND: begin
                        if (table_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_hit) begin
                            n_count = r_count - 1'b1;
                        end else begin
                            n_status = STAT_NOMATCH;
                        end
                    end
                    CMD_BEST, CMD_FIND_NUM, CMD_FIND_ADDR: begin
                        if (!r_hit) begin
                            n_status = STAT_NOMATCH;
                        end
                    end
                    CMD_CLEAR: n_count = '0;
                    default: ;
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = lookup_hit;
                    n_out_status = r_status;
                    n_out_entry  = lookup_hit ? r_res : '0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step       <= n_step;
        r_cmd        <= n_cmd;
        r_req        <= n_req;
        r_need       <= n_need;
        r_best       <= n_best;
        r_hit        <= n_hit;
        r_sel        <= n_sel;
        r_res        <= n_res;
        r_status     <= n_status;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
    end

    always_comb begin
        o_cell_ctrl.rotate  = r_state == S_SCAN;
        o_cell_ctrl.compact = (r_state == S_UPDATE) && (r_cmd == CMD_REMOVE) && r_hit;
        o_cell_ctrl.write   = (r_state == S_UPDATE) && (r_cmd == CMD_APPEND) && !table_full;
        o_cell_ctrl.sel     = o_cell_ctrl.write ? r_count[IDX_W-1:0] : r_sel;
    end

    assign o_wr_entry   = r_req;
    assign o_req_ready  = r_state == S_IDLE;
    assign o_res_valid  = r_out_valid;
    assign o_res_found  = r_out_found;
    assign o_res_status = r_out_status;
    assign o_res_entry  = r_out_entry;

endmodule

// ===== design/best_fit_slot_table_top.sv =====
// best_fit_slot_table_top: ordered compartment table with lookup and best-fit query.
// Depends on bfst_pkg, bfst_cell and bfst_ctrl.
//
//  channel  | dir | tdata                                  | tuser
//  ---------+-----+----------------------------------------+----------------------
//  s_axis   | in  | width, height, number, address         | command
//  m_axis   | out | number, address, width, height         | found, status
//
// Append, clear and unknown commands go from idle via update and done to the result.
// Remove, best fit and both finds add a scan state first: the ring of cells
// rotates once, bringing one entry a cycle past the search unit at its head.
// One request is in work at a time; the next is taken while the result waits.
// Reset empties the table at once; entry contents are undefined until written.
// A stalled result holds the sequencer in its final state, not the input side.

module best_fit_slot_table_top import bfst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // width, height, number, address, pad
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // number, address, width, height, pad
    output logic [OUT_USER_W-1:0] m_axis_tuser    // found, status
);

    t_entry     req_entry;
    t_entry     head;
    t_entry     wr_entry;
    t_entry     res_entry;
    t_cell_ctrl cell_ctrl;
    logic       res_found;
    t_status    res_status;
    t_entry     cells [SLOTS];

    assign req_entry.width   = s_axis_tdata[7:0];
    assign req_entry.height  = s_axis_tdata[15:8];
    assign req_entry.number  = s_axis_tdata[23:16];
    assign req_entry.address = s_axis_tdata[30:24];

    bfst_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_req_cmd    (s_axis_tuser),
        .i_req_entry  (req_entry),
        .i_head       (head),
        .o_cell_ctrl  (cell_ctrl),
        .o_wr_entry   (wr_entry),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res_found  (res_found),
        .o_res_status (res_status),
        .o_res_entry  (res_entry)
    );

    // cell k takes cell k+1; the last wraps round to the head
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        localparam int NXT = (k + 1) % SLOTS;
        bfst_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_index    (IDX_W'(k)),
            .i_wr_entry (wr_entry),
            .i_next     (cells[NXT]),
            .o_entry    (cells[k])
        );
    end

    assign head = cells[0];

    assign m_axis_tdata = {1'b0, res_entry.height, res_entry.width,
                           res_entry.address, res_entry.number};
    assign m_axis_tuser = {res_status, res_found};

endmodule

// ===== design/bfst_checker.sv =====
// bfst_checker: port-level checks on the compartment table, bound to the top level.
// Depends on bfst_pkg and best_fit_slot_table_top.

module bfst_checker import bfst_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // a stalled result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // only one request in work: ready drops after a request is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == STAT_OK)
        else $error("match reported with bad status");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("data present without a match");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[2:1] == STAT_OK || m_axis_tuser[2:1] == STAT_FULL
            || m_axis_tuser[2:1] == STAT_NOMATCH)
        else $error("undefined status code");

endmodule

bind best_fit_slot_table_top bfst_checker u_bfst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/tb_best_fit_slot_table_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for best_fit_slot_table_top: a directed table, then random requests,
// each reply checked against a typed reply or a predictor of the compartment table. Depends on bfst_pkg.

module tb_best_fit_slot_table_top;
    import bfst_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CALM_TAIL    = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int PLAN_LEN     = 25;

    typedef struct packed {
        logic              found;
        logic [NUM_W-1:0]  number;
        logic [ADDR_W-1:0] address;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        t_status           status;
    } t_reply;

    localparam t_reply R_OK      = '{1'b0, '0, '0, '0, '0, STAT_OK};
    localparam t_reply R_FULL    = '{1'b0, '0, '0, '0, '0, STAT_FULL};
    localparam t_reply R_NOMATCH = '{1'b0, '0, '0, '0, '0, STAT_NOMATCH};

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [NUM_W-1:0]  num;
        logic [ADDR_W-1:0] addr;
        int                reps;   // repeated with number and address stepped by one
        bit                typed;  // reply typed in below, otherwise predicted
        t_reply            want;
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // width, height, number, address, pad
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // number, address, width, height, pad
    logic [OUT_USER_W-1:0] m_axis_tuser;        // found, status

    best_fit_slot_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_step directed_plan [0:PLAN_LEN-1] = '{
        '{CMD_BEST,      8'd0,   8'd0,   8'd0,   7'd0,   1,  1'b1, R_NOMATCH},
        '{CMD_FIND_NUM,  8'd0,   8'd0,   8'd0,   7'd0,   1,  1'b1, R_NOMATCH},
        '{CMD_FIND_ADDR, 8'd0,   8'd0,   8'd0,   7'd127, 1,  1'b1, R_NOMATCH},
        '{CMD_REMOVE,    8'd0,   8'd0,   8'd5,   7'd0,   1,  1'b1, R_NOMATCH},
        '{CMD_RSVD_LO,   8'd255, 8'd255, 8'd255, 7'd127, 1,  1'b1, R_OK},
        '{CMD_RSVD_HI,   8'd0,   8'd0,   8'd0,   7'd0,   1,  1'b1, R_OK},
        '{CMD_APPEND,    8'd255, 8'd255, 8'd255, 7'd127, 1,  1'b1, R_OK},
        '{CMD_APPEND,    8'd0,   8'd0,   8'd0,   7'd0,   1,  1'b1, R_OK},
        '{CMD_APPEND,    8'd10,  8'd20,  8'd3,   7'd5,   1,  1'b1, R_OK},
        '{CMD_APPEND,    8'd20,  8'd10,  8'd4,   7'd6,   1,  1'b1, R_OK},
        '{CMD_BEST,      8'd10,  8'd10,  8'd0,   7'd0,   1,  1'b0, R_OK},  // tie, earlier wins
        '{CMD_BEST,      8'd255, 8'd255, 8'd0,   7'd0,   1,  1'b0, R_OK},
        '{CMD_BEST,      8'd0,   8'd0,   8'd0,   7'd0,   1,  1'b0, R_OK},
        '{CMD_BEST,      8'd21,  8'd21,  8'd0,   7'd0,   1,  1'b0, R_OK},
        '{CMD_FIND_NUM,  8'd0,   8'd0,   8'd255, 7'd0,   1,  1'b0, R_OK},
        '{CMD_FIND_ADDR, 8'd0,   8'd0,   8'd0,   7'd0,   1,  1'b0, R_OK},
        '{CMD_REMOVE,    8'd0,   8'd0,   8'd0,   7'd0,   1,  1'b1, R_OK},
        '{CMD_FIND_NUM,  8'd0,   8'd0,   8'd0,   7'd0,   1,  1'b0, R_OK},
        '{CMD_CLEAR,     8'd0,   8'd0,   8'd0,   7'd0,   1,  1'b1, R_OK},
        '{CMD_BEST,      8'd1,   8'd1,   8'd0,   7'd0,   1,  1'b1, R_NOMATCH},
        '{CMD_APPEND,    8'd30,  8'd40,  8'd100, 7'd64,  16, 1'b1, R_OK},
        '{CMD_APPEND,    8'd1,   8'd1,   8'd200, 7'd1,   1,  1'b1, R_FULL},
        '{CMD_REMOVE,    8'd0,   8'd0,   8'd108, 7'd0,   1,  1'b0, R_OK},
        '{CMD_FIND_ADDR, 8'd0,   8'd0,   8'd0,   7'd79,  1,  1'b0, R_OK},
        '{CMD_CLEAR,     8'd0,   8'd0,   8'd0,   7'd0,   1,  1'b1, R_OK}
    };

    // predicted table contents
    t_entry slot_tab [SLOTS];
    int     slot_count = 0;

    t_reply awaited_replies [$];
    int     error_count = 0;
    bit     idle_on = 1'b1;
    int     hold_cycles = 0;
    int     quiet_cycles = 0;

    wire in_fire  = s_axis_tvalid && s_axis_tready;
    wire out_fire = m_axis_tvalid && m_axis_tready;

    function automatic t_reply predict_table_reply(input logic [CMD_W-1:0] cmd,
                                                   input logic [DIM_W-1:0] w,
                                                   input logic [DIM_W-1:0] h,
                                                   input logic [NUM_W-1:0] num,
                                                   input logic [ADDR_W-1:0] addr);
        t_reply r;
        int     hit_idx;
        int     best_left;
        int     left;
        r = R_OK;
        hit_idx = -1;
        best_left = 65535;
        case (cmd)
            CMD_APPEND: begin
                if (slot_count >= SLOTS) begin
                    r = R_FULL;
                end else begin
                    slot_tab[slot_count] = '{w, h, num, addr};
                    slot_count++;
                end
            end
            CMD_REMOVE: begin
                r = R_NOMATCH;
                for (int i = 0; i < slot_count; i++) begin
                    if (slot_tab[i].number == num) begin
                        for (int j = i; j + 1 < slot_count; j++) slot_tab[j] = slot_tab[j + 1];
                        slot_count--;
                        r = R_OK;
                        break;
                    end
                end
            end
            CMD_BEST: begin
                for (int i = 0; i < slot_count; i++) begin
                    if (slot_tab[i].width >= w && slot_tab[i].height >= h) begin
                        left = int'(slot_tab[i].width) * int'(slot_tab[i].height)
                             - int'(w) * int'(h);
                        if (left < best_left) begin
                            best_left = left;
                            hit_idx = i;
                        end
                    end
                end
            end
            CMD_FIND_NUM, CMD_FIND_ADDR: begin
                for (int i = 0; i < slot_count; i++) begin
                    if (hit_idx < 0 && ((cmd == CMD_FIND_NUM) ? slot_tab[i].number == num
                                                              : slot_tab[i].address == addr))
                        hit_idx = i;
                end
            end
            CMD_CLEAR: slot_count = 0;
            default: ;
        endcase
        if (cmd == CMD_BEST || cmd == CMD_FIND_NUM || cmd == CMD_FIND_ADDR) begin
            if (hit_idx < 0) begin
                r = R_NOMATCH;
            end else begin
                r.found   = 1'b1;
                r.number  = slot_tab[hit_idx].number;
                r.address = slot_tab[hit_idx].address;
                r.width   = slot_tab[hit_idx].width;
                r.height  = slot_tab[hit_idx].height;
            end
        end
        return r;
    endfunction

    task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [DIM_W-1:0] w,
                                 input logic [DIM_W-1:0] h, input logic [NUM_W-1:0] num,
                                 input logic [ADDR_W-1:0] addr, input t_reply want,
                                 input bit typed);
        t_reply predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, addr, num, h, w};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_table_reply(cmd, w, h, num, addr);
        awaited_replies.push_back(typed ? want : predicted);
    endtask

    // numbers and addresses mostly from a small pool so lookups and removes hit
    task automatic random_request();
        logic [CMD_W-1:0]  cmd;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [NUM_W-1:0]  num;
        logic [ADDR_W-1:0] addr;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      cmd = CMD_APPEND;
        else if (pick < 42) cmd = CMD_REMOVE;
        else if (pick < 67) cmd = CMD_BEST;
        else if (pick < 79) cmd = CMD_FIND_NUM;
        else if (pick < 91) cmd = CMD_FIND_ADDR;
        else if (pick < 94) cmd = CMD_CLEAR;
        else                cmd = $urandom_range(0, 1) ? CMD_RSVD_HI : CMD_RSVD_LO;
        w = DIM_W'($urandom_range(0, 255));
        h = DIM_W'($urandom_range(0, 255));
        if (cmd == CMD_BEST) begin
            w = w >> $urandom_range(0, 3);
            h = h >> $urandom_range(0, 3);
        end
        num  = ($urandom_range(0, 3) != 0) ? NUM_W'($urandom_range(0, 19))
                                           : NUM_W'($urandom_range(0, 255));
        addr = ($urandom_range(0, 3) != 0) ? ADDR_W'($urandom_range(0, 19))
                                           : ADDR_W'($urandom_range(0, 127));
        offer_request(cmd, w, h, num, addr, R_OK, 1'b0);
    endtask

    task automatic check_reply();
        t_reply exp_r;
        if (awaited_replies.size() == 0) begin
            $error("reply with none awaited: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
            error_count++;
        end else begin
            exp_r = awaited_replies.pop_front();
            if (m_axis_tuser[0] !== exp_r.found) begin
                $error("found: expected %0d, got %0d", exp_r.found, m_axis_tuser[0]);
                error_count++;
            end
            if (m_axis_tuser[2:1] !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser[2:1]);
                error_count++;
            end
            if (m_axis_tdata[7:0] !== exp_r.number) begin
                $error("number: expected %0d, got %0d", exp_r.number, m_axis_tdata[7:0]);
                error_count++;
            end
            if (m_axis_tdata[14:8] !== exp_r.address) begin
                $error("address: expected %0d, got %0d", exp_r.address, m_axis_tdata[14:8]);
                error_count++;
            end
            if (m_axis_tdata[22:15] !== exp_r.width) begin
                $error("width: expected %0d, got %0d", exp_r.width, m_axis_tdata[22:15]);
                error_count++;
            end
            if (m_axis_tdata[30:23] !== exp_r.height) begin
                $error("height: expected %0d, got %0d", exp_r.height, m_axis_tdata[30:23]);
                error_count++;
            end
        end
    endtask

    // reply side: check, then decide ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && out_fire) check_reply();
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (i_rst_n && idle_on && $urandom_range(0, 9) == 0) begin
            hold_cycles <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (in_fire || out_fire) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_LEN; r++) begin
            for (int k = 0; k < directed_plan[r].reps; k++) begin
                offer_request(directed_plan[r].cmd, directed_plan[r].w, directed_plan[r].h,
                              NUM_W'(directed_plan[r].num + k),
                              ADDR_W'(directed_plan[r].addr + k),
                              directed_plan[r].want, directed_plan[r].typed);
            end
        end

        // calm stretches (no gaps, no stalls) now and then, and all calm near the end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_on = (i < RANDOM_ITEMS - CALM_TAIL) && ((i / 100) % 4 != 3);
            random_request();
        end
        s_axis_tvalid <= 1'b0;

        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (4 * (SLOTS + 3)) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
